FILE: rtl/khrd_pkg.sv
`default_nettype none
package khrd_pkg;

  localparam int TIMER_BITS = 16;
  localparam int CFG_BITS   = 16;
  localparam int IDX_BITS   = 2;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [CFG_BITS-1:0]   dur_t;
  typedef logic [1:0]            event_t;
  typedef logic [IDX_BITS-1:0]   cfg_idx_t;

  localparam logic OP_SCAN  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  localparam event_t EV_NONE   = 2'd0;
  localparam event_t EV_PUSH   = 2'd1;
  localparam event_t EV_HOLD   = 2'd2;
  localparam event_t EV_REPEAT = 2'd3;

  localparam cfg_idx_t REG_PUSH   = 2'd0;
  localparam cfg_idx_t REG_HOLD   = 2'd1;
  localparam cfg_idx_t REG_REPEAT = 2'd2;

  localparam dur_t PUSH_RESET   = 16'd20;
  localparam dur_t HOLD_RESET   = 16'd500;
  localparam dur_t REPEAT_RESET = 16'd100;

  typedef struct packed {
    dur_t push_ticks;
    dur_t hold_ticks;
    dur_t repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic   event_matched;
    event_t latched_event;
  } res_t;

  // durations wider than the timer clamp to all ones
  function automatic timer_t load_dur(input dur_t d);
    logic [CFG_BITS+TIMER_BITS-1:0] wide;
    logic [CFG_BITS+TIMER_BITS-1:0] cap;
    wide = {{TIMER_BITS{1'b0}}, d};
    cap  = {{CFG_BITS{1'b0}}, {TIMER_BITS{1'b1}}};
    if (wide > cap) begin
      return {TIMER_BITS{1'b1}};
    end
    return wide[TIMER_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/khrd_cfg.sv
`default_nettype none
module khrd_cfg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire khrd_pkg::cfg_idx_t cfg_index,
  input  wire khrd_pkg::dur_t     cfg_data,
  output khrd_pkg::cfg_t          cfg
);
  import khrd_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.push_ticks   <= PUSH_RESET;
      cfg.hold_ticks   <= HOLD_RESET;
      cfg.repeat_ticks <= REPEAT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PUSH:   cfg.push_ticks   <= cfg_data;
        REG_HOLD:   cfg.hold_ticks   <= cfg_data;
        REG_REPEAT: cfg.repeat_ticks <= cfg_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/khrd_core.sv
`default_nettype none
module khrd_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic             operation,
  input  wire logic             key_down,
  input  wire khrd_pkg::event_t wanted_event,
  input  wire khrd_pkg::cfg_t   cfg,
  output khrd_pkg::res_t        res
);
  import khrd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WAIT   = 3'd1,
    PH_PUSH   = 3'd2,
    PH_HOLD   = 3'd3,
    PH_REPEAT = 3'd4
  } phase_t;

  phase_t phase, phase_next;
  timer_t timer, timer_next;
  event_t pending, pending_next;
  logic   matched;
  logic   expired;

  assign expired = (timer == '0);

  always_comb begin
    phase_next   = phase;
    timer_next   = timer;
    pending_next = pending;
    matched      = 1'b0;
    if (accept) begin
      if (operation == OP_SCAN) begin
        // test first, then count down with saturation
        timer_next = expired ? timer : timer - 1'b1;
        unique case (phase)
          PH_WAIT: begin
            if (key_down) begin
              timer_next = load_dur(cfg.push_ticks);
              phase_next = PH_PUSH;
            end
          end
          PH_PUSH: begin
            if (!key_down) begin
              phase_next = PH_IDLE;
            end else if (expired) begin
              timer_next   = load_dur(cfg.hold_ticks);
              pending_next = EV_PUSH;
              phase_next   = PH_HOLD;
            end
          end
          PH_HOLD: begin
            if (!key_down) begin
              phase_next = PH_IDLE;
            end else if (expired) begin
              timer_next   = load_dur(cfg.repeat_ticks);
              pending_next = EV_HOLD;
              phase_next   = PH_REPEAT;
            end
          end
          PH_REPEAT: begin
            if (!key_down) begin
              phase_next = PH_IDLE;
            end else if (expired) begin
              timer_next   = load_dur(cfg.repeat_ticks);
              pending_next = EV_REPEAT;
            end
          end
          default: phase_next = PH_WAIT;
        endcase
      end else if (wanted_event == pending) begin
        pending_next = EV_NONE;
        matched      = 1'b1;
      end
    end
  end

  assign res.event_matched = matched;
  assign res.latched_event = pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      timer   <= '0;
      pending <= EV_NONE;
    end else begin
      phase   <= phase_next;
      timer   <= timer_next;
      pending <= pending_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/khrd_outq.sv
`default_nettype none
module khrd_outq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire khrd_pkg::res_t push_data,
  output logic                can_push,
  output logic                out_valid,
  input  wire logic           out_ready,
  output khrd_pkg::res_t      out_data
);
  import khrd_pkg::*;

  logic main_valid, skid_valid;
  res_t main_data, skid_data;
  logic pop;

  assign pop       = main_valid && out_ready;
  assign can_push  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= push;
      end else begin
        main_valid <= push;
      end
    end else if (!main_valid) begin
      main_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload path, no reset needed
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
        if (push) begin
          skid_data <= push_data;
        end
      end else begin
        main_data <= push_data;
      end
    end else if (!main_valid) begin
      main_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid word held with empty main stage");

  a_stall_keeps_word: assert property (@(posedge clk) disable iff (rst)
    (main_valid && !out_ready) |=> main_valid)
    else $error("word dropped while receiver stalled");

  a_empty_push_lands: assert property (@(posedge clk) disable iff (rst)
    (!main_valid && push) |=> (main_valid && main_data == $past(push_data)))
    else $error("word pushed into empty queue not presented");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !pop) |=> (skid_valid && $stable(skid_data)))
    else $error("skid word overwritten");

endmodule
`default_nettype wire

FILE: rtl/key_press_hold_repeat_detector_top.sv
// Key press / hold / auto-repeat qualifier.
// Input channel (in_valid/in_ready): operation selects a scan tick, which
// samples key_down and advances the press timer, or a check, which compares
// wanted_event with the latched event and consumes it on a match.
// Output channel (out_valid/out_ready): exactly one word per input word,
// event_matched plus the latched event after the step, in input order.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0..2 picks
// push, hold or repeat ticks; other indexes are ignored. Write only while idle.
// Each result is registered in the output buffer as its input is accepted.
// Throughput: one word per cycle while in_ready is high; the state update
// is combinational from accepted word to phase, timer and event registers.
// A two-word output buffer lets input keep flowing for one word while the
// receiver stalls; in_ready drops only when both words are held.
// Reset (rst, synchronous): phase idle, timer zero, no event latched,
// registers back to 20 / 500 / 100 ticks, output buffer empty.
`default_nettype none
module key_press_hold_repeat_detector_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               operation,
  input  wire logic               key_down,
  input  wire khrd_pkg::event_t   wanted_event,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    event_matched,
  output khrd_pkg::event_t        latched_event,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire khrd_pkg::cfg_idx_t cfg_index,
  input  wire khrd_pkg::dur_t     cfg_data
);
  import khrd_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_data;
  logic accept;

  assign accept = in_valid && in_ready;

  khrd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  khrd_core u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .operation    (operation),
    .key_down     (key_down),
    .wanted_event (wanted_event),
    .cfg          (cfg),
    .res          (res)
  );

  khrd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign event_matched = out_data.event_matched;
  assign latched_event = out_data.latched_event;

endmodule
`default_nettype wire

FILE: tb/sv/khrd_tb_pkg.sv
`timescale 1ns / 1ps
package khrd_tb_pkg;
  import khrd_pkg::*;

  typedef enum logic [2:0] {
    PHASE_IDLE,
    PHASE_WAIT,
    PHASE_PUSH,
    PHASE_HOLD,
    PHASE_REPEAT
  } key_phase_e;

  class key_event_tracker;
    dur_t push_ticks = PUSH_RESET;
    dur_t hold_ticks = HOLD_RESET;
    dur_t repeat_ticks = REPEAT_RESET;
    key_phase_e phase = PHASE_IDLE;
    timer_t timer = '0;
    event_t latched = EV_NONE;
    res_t awaited_reports[$];
    int unsigned mismatches = 0;
    int unsigned reports_checked = 0;
    int unsigned hits = 0;
    int unsigned events_seen[4] = '{0, 0, 0, 0};

    function void set_register(cfg_idx_t idx, dur_t value);
      case (idx)
        REG_PUSH: push_ticks = value;
        REG_HOLD: hold_ticks = value;
        REG_REPEAT: repeat_ticks = value;
        default: ;
      endcase
    endfunction

    function void load_timer(dur_t d);
      longint unsigned cap;
      cap = (longint'(1) << TIMER_BITS) - 1;
      if (longint'(d) > cap) timer = '1;
      else timer = timer_t'(d);
    endfunction

    function void latch_event(event_t ev);
      latched = ev;
      events_seen[ev]++;
    endfunction

    function void scan_key(logic down);
      logic expired;
      expired = (timer == '0);
      if (!expired) timer = timer - 1'b1;
      case (phase)
        PHASE_WAIT: begin
          if (down) begin
            load_timer(push_ticks);
            phase = PHASE_PUSH;
          end
        end
        PHASE_PUSH: begin
          if (!down) begin
            phase = PHASE_IDLE;
          end else if (expired) begin
            load_timer(hold_ticks);
            latch_event(EV_PUSH);
            phase = PHASE_HOLD;
          end
        end
        PHASE_HOLD: begin
          if (!down) begin
            phase = PHASE_IDLE;
          end else if (expired) begin
            load_timer(repeat_ticks);
            latch_event(EV_HOLD);
            phase = PHASE_REPEAT;
          end
        end
        PHASE_REPEAT: begin
          if (!down) begin
            phase = PHASE_IDLE;
          end else if (expired) begin
            load_timer(repeat_ticks);
            latch_event(EV_REPEAT);
          end
        end
        default: phase = PHASE_WAIT;
      endcase
    endfunction

    // one accepted input word -> one expected result word
    function void note_word(logic op, logic down, event_t wanted);
      res_t r;
      r.event_matched = 1'b0;
      if (op == OP_SCAN) begin
        scan_key(down);
      end else if (wanted == latched) begin
        latched = EV_NONE;
        r.event_matched = 1'b1;
        hits++;
      end
      r.latched_event = latched;
      awaited_reports.push_back(r);
    endfunction

    function void check_report(logic matched, event_t ev);
      res_t want;
      if (awaited_reports.size() == 0) begin
        $error("result word with nothing expected: event_matched=%0d latched_event=%0d",
               matched, ev);
        mismatches++;
        return;
      end
      want = awaited_reports.pop_front();
      reports_checked++;
      if (matched !== want.event_matched) begin
        $error("event_matched: expected %0d, actual %0d", want.event_matched, matched);
        mismatches++;
      end
      if (ev !== want.latched_event) begin
        $error("latched_event: expected %0d, actual %0d", want.latched_event, ev);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return awaited_reports.size();
    endfunction

    function event_t current_event();
      return latched;
    endfunction
  endclass

endpackage

FILE: tb/sv/key_press_hold_repeat_detector_top_test.sv
`timescale 1ns / 1ps
module key_press_hold_repeat_detector_top_test;
  import khrd_pkg::*;
  import khrd_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD_OFF = 64;
  localparam int SEGMENTS = 12;
  localparam int SEGMENT_WORDS = 150;
  localparam cfg_idx_t REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = OP_SCAN;
  logic key_down = 1'b0;
  event_t wanted_event = EV_NONE;
  logic out_valid;
  logic out_ready = 1'b0;
  logic event_matched;
  event_t latched_event;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = REG_PUSH;
  dur_t cfg_data = '0;

  key_event_tracker tracker = new();
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned reg_writes = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_off_request = 1'b0;

  key_press_hold_repeat_detector_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .key_down(key_down),
    .wanted_event(wanted_event),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_matched(event_matched),
    .latched_event(latched_event),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_report(event_matched, latched_event);
  end

  // result side: random stalls, plus one long hold-off when asked
  initial begin
    int stall;
    wait (!rst);
    forever begin
      @(negedge clk);
      stall = rx_idle_on ? $urandom_range(0, 9) : 0;
      if (hold_off_request) begin
        stall = LONG_HOLD_OFF;
        hold_off_request = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_word(logic op, logic down, event_t wanted);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    key_down <= down;
    wanted_event <= wanted;
    do @(posedge clk); while (!in_ready);
    tracker.note_word(op, down, wanted);
    words_sent++;
  endtask

  task automatic scan(logic down);
    send_word(OP_SCAN, down, event_t'($urandom_range(0, 3)));
  endtask

  task automatic check(event_t wanted);
    send_word(OP_CHECK, 1'($urandom_range(0, 1)), wanted);
  endtask

  // stop offering words and wait until every result word is back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, dur_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(idx, value);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_config(dur_t p, dur_t h, dur_t r);
    write_reg(REG_PUSH, p);
    write_reg(REG_HOLD, h);
    write_reg(REG_REPEAT, r);
    if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, dur_t'($urandom_range(0, 65535)));
  endtask

  function automatic event_t pick_wanted();
    if ($urandom_range(0, 1) != 0) return tracker.current_event();
    return event_t'($urandom_range(0, 3));
  endfunction

  // release for a tick or few, then hold the key with polls mixed in
  task automatic press_sequence();
    int unsigned span;
    int unsigned downs;
    repeat ($urandom_range(1, 3)) scan(1'b0);
    span = tracker.push_ticks + tracker.hold_ticks + 4 * tracker.repeat_ticks + 6;
    if (span > 200) span = 200;
    downs = $urandom_range(0, span);
    repeat (downs) begin
      if ($urandom_range(0, 3) == 0) check(pick_wanted());
      scan(1'b1);
    end
    if ($urandom_range(0, 1) != 0) check(pick_wanted());
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 8))
      send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                event_t'($urandom_range(0, 3)));
  endtask

  initial begin
    int unsigned target;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values: empty poll hits, idle/wait/push/release path
    check(EV_NONE);
    check(EV_REPEAT);
    scan(1'b0);
    scan(1'b0);
    scan(1'b1);
    scan(1'b0);
    settle();

    // zero push and repeat durations, hold of one: repeat events on consecutive ticks
    apply_config(16'd0, 16'd1, 16'd0);
    write_reg(REG_UNUSED, 16'd7);
    scan(1'b1);
    scan(1'b1);
    scan(1'b1);
    check(EV_HOLD);
    scan(1'b1);
    scan(1'b1);
    scan(1'b1);
    check(EV_REPEAT);
    scan(1'b1);
    scan(1'b0);
    check(EV_NONE);
    check(EV_REPEAT);
    check(EV_PUSH);
    check(EV_NONE);
    scan(1'b1);
    settle();

    // full-width push time, run back to back
    apply_config(16'hFFFF, 16'd1, 16'd1);
    write_reg(REG_UNUSED, 16'h0000);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    scan(1'b0);
    scan(1'b0);
    repeat (40) scan(1'b1);
    check(EV_PUSH);
    repeat (4) scan(1'b1);
    scan(1'b0);
    settle();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: apply_config(PUSH_RESET, HOLD_RESET, REPEAT_RESET);
        1: apply_config(16'd0, 16'd0, 16'd0);
        2: apply_config(16'd2, 16'hFFFF, 16'hFFFF);
        3: apply_config(16'd1, 16'd3, 16'hFFFF);
        default: begin
          if ($urandom_range(0, 3) == 0)
            apply_config(dur_t'($urandom_range(0, 30)), dur_t'($urandom_range(0, 30)),
                         dur_t'($urandom_range(1, 30)));
          else
            apply_config(dur_t'($urandom_range(0, 6)), dur_t'($urandom_range(0, 6)),
                         dur_t'($urandom_range(0, 6)));
        end
      endcase
      tx_idle_on = (seg % 4 != 3);
      rx_idle_on = (seg % 4 != 3) && (seg % 5 != 2);
      if (seg == 4 || seg == 9) hold_off_request = 1'b1;
      target = words_sent + SEGMENT_WORDS;
      while (words_sent < target) begin
        if ($urandom_range(0, 4) == 0) noise_burst();
        else press_sequence();
      end
      settle();
    end

    repeat (5) @(posedge clk);
    $display("Run covered %0d words (%0d polls hit), %0d register writes, %0d cycles",
             words_sent, tracker.hits, reg_writes, cycle_count);
    $display("Events latched: push %0d, hold %0d, repeat %0d; %0d results compared",
             tracker.events_seen[EV_PUSH], tracker.events_seen[EV_HOLD],
             tracker.events_seen[EV_REPEAT], tracker.reports_checked);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
